// File: rtl/core/rhht_pkg.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Shared constants for the hash table core and its checker.
// ----------------------------------------------------------------------------
package rhht_pkg;

    localparam int unsigned SLOT_COUNT_DEF   = 64;
    localparam int unsigned LOAD_LIMIT_W     = 7;
    localparam int unsigned LOAD_LIMIT_RESET = 48;
    localparam int unsigned KEY_W            = 32;
    localparam int unsigned VALUE_W          = 64;

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_DEL   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

endpackage

// File: rtl/core/robin_hood_hash_table_unit.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table unit
// Open-addressed key/value table with Robin Hood linear probing, tombstone
// deletes and a programmable load limit. All slots live in one RAM.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction
//  input     s_valid/s_ready, cmd key hash value     in
//  result    m_valid/m_ready, hit new full value     out
//  config    cfg_wr_en, cfg_wr_data                  in
//
// Each get, delete or set probes slots from the key's home slot, and a set
// that inserts walks the slots once more; the RAM read port visits one slot
// a cycle. A hash is reduced by a reciprocal multiplication, with the quotient
// registered before the remainder, unless the slot count is a power of two.
// A clear, and reset, sweep every RAM slot, during which no beat is accepted.
// A stalled result holds the next beat in the unit until the result register
// frees up.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_unit #(
    parameter int unsigned SLOT_COUNT = rhht_pkg::SLOT_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rhht_pkg::LOAD_LIMIT_W-1:0] cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic [rhht_pkg::KEY_W-1:0]        s_key,
    input  logic [rhht_pkg::KEY_W-1:0]        s_key_hash,
    input  logic [rhht_pkg::VALUE_W-1:0]      s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic                              m_new_key,
    output logic                              m_full_res,
    output logic [rhht_pkg::VALUE_W-1:0]      m_read_value
);

    localparam int unsigned AW   = $clog2(SLOT_COUNT);
    localparam bit          POW2 = (SLOT_COUNT == (1 << AW));
    localparam int unsigned KW   = rhht_pkg::KEY_W;
    localparam int unsigned VW   = rhht_pkg::VALUE_W;
    localparam int unsigned EW   = 2 + AW + KW + VW;
    localparam int unsigned LW   = ((AW + 1 > rhht_pkg::LOAD_LIMIT_W) ?
                                    AW + 1 : rhht_pkg::LOAD_LIMIT_W) + 1;
    localparam int unsigned RSH  = KW + AW;
    localparam logic [32:0] MAGIC = 33'(((65'd1 << RSH) + 65'(SLOT_COUNT) - 65'd1)
                                        / 65'(SLOT_COUNT));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_CLR  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic                    init_reg, init_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW:0]             dist_reg, dist_next;
    logic [AW-1:0]           home_reg, home_next;
    logic                    cnt_reg, cnt_next;
    logic [KW-1:0]           quot_reg, quot_next;
    logic [AW:0]             fill_reg, fill_next;
    logic [6:0]              lim_reg, lim_next;
    logic [1:0]              cmd_reg, cmd_next;
    logic [KW-1:0]           key_reg, key_next;
    logic [KW-1:0]           hash_reg, hash_next;
    logic [VW-1:0]           val_reg, val_next;
    logic                    hit_res_reg, hit_res_next;
    logic                    new_res_reg, new_res_next;
    logic                    full_res_reg, full_res_next;
    logic [VW-1:0]           rval_res_reg, rval_res_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_hit_reg, m_hit_next;
    logic                    m_new_reg, m_new_next;
    logic                    m_full_reg, m_full_next;
    logic [VW-1:0]           m_rval_reg, m_rval_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [EW-1:0]           ram_rdata;

    logic [1:0]              rd_st;
    logic [AW-1:0]           rd_dist;
    logic [KW-1:0]           rd_key;
    logic [VW-1:0]           rd_val;
    logic [AW-1:0]           idx_inc;
    logic [KW+32:0]          mod_prod;
    logic [AW-1:0]           mod_rem;
    logic [LW-1:0]           lim_ext;
    logic [LW-1:0]           lim_cap;
    logic                    over_limit;
    logic                    found;
    logic                    stop_miss;

    rhht_ram #(
        .WIDTH(EW),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign rd_st   = ram_rdata[EW-1 -: 2];
    assign rd_dist = ram_rdata[VW+KW +: AW];
    assign rd_key  = ram_rdata[VW +: KW];
    assign rd_val  = ram_rdata[VW-1:0];

    assign idx_inc   = (idx_reg == AW'(SLOT_COUNT - 1)) ? '0 : idx_reg + 1'b1;
    assign mod_prod  = (KW + 33)'(hash_reg) * (KW + 33)'(MAGIC);
    assign mod_rem   = AW'(hash_reg - KW'(quot_reg * KW'(SLOT_COUNT)));
    assign lim_ext    = LW'(lim_reg);
    assign lim_cap    = (lim_ext > LW'(SLOT_COUNT)) ? LW'(SLOT_COUNT) : lim_ext;
    assign over_limit = (LW'(fill_reg) + 1'b1) > lim_cap;
    assign found      = (rd_st == rhht_pkg::ST_LIVE) && (rd_key == key_reg);
    assign stop_miss  = (rd_st == rhht_pkg::ST_EMPTY)
                     || ((rd_st == rhht_pkg::ST_LIVE) && ((AW + 1)'(rd_dist) < dist_reg))
                     || (dist_reg == (AW + 1)'(SLOT_COUNT - 1));

    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        idx_next      = idx_reg;
        dist_next     = dist_reg;
        home_next     = home_reg;
        cnt_next      = cnt_reg;
        quot_next     = quot_reg;
        fill_next     = fill_reg;
        lim_next      = cfg_wr_en ? cfg_wr_data : lim_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        hash_next     = hash_reg;
        val_next      = val_reg;
        hit_res_next  = hit_res_reg;
        new_res_next  = new_res_reg;
        full_res_next = full_res_reg;
        rval_res_next = rval_res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_hit_next    = m_hit_reg;
        m_new_next    = m_new_reg;
        m_full_next   = m_full_reg;
        m_rval_next   = m_rval_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = '0;
        ram_raddr     = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next      = s_cmd;
                    key_next      = s_key;
                    hash_next     = s_key_hash;
                    val_next      = s_write_value;
                    hit_res_next  = 1'b0;
                    new_res_next  = 1'b0;
                    full_res_next = 1'b0;
                    rval_res_next = '0;
                    dist_next     = '0;
                    cnt_next      = 1'b0;
                    if (s_cmd == rhht_pkg::CMD_CLEAR) begin
                        idx_next   = '0;
                        state_next = S_CLR;
                    end else if (POW2) begin
                        home_next  = s_key_hash[AW-1:0];
                        idx_next   = s_key_hash[AW-1:0];
                        ram_raddr  = s_key_hash[AW-1:0];
                        state_next = S_LOOK;
                    end else begin
                        home_next  = '0;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (!cnt_reg) begin
                    quot_next = KW'(mod_prod >> RSH);
                    cnt_next  = 1'b1;
                end else begin
                    home_next  = mod_rem;
                    idx_next   = mod_rem;
                    ram_raddr  = mod_rem;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (found) begin
                    hit_res_next = 1'b1;
                    state_next   = S_OUT;
                    if (cmd_reg == rhht_pkg::CMD_GET) begin
                        rval_res_next = rd_val;
                    end else if (cmd_reg == rhht_pkg::CMD_DEL) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rhht_pkg::ST_TOMB, AW'(0), rd_key, rd_val};
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = {rhht_pkg::ST_LIVE, rd_dist, rd_key, val_reg};
                    end
                end else if (stop_miss) begin
                    state_next = S_OUT;
                    if (cmd_reg == rhht_pkg::CMD_SET) begin
                        if (over_limit) begin
                            full_res_next = 1'b1;
                        end else begin
                            idx_next   = home_reg;
                            dist_next  = '0;
                            ram_raddr  = home_reg;
                            state_next = S_INS;
                        end
                    end
                end else begin
                    idx_next  = idx_inc;
                    dist_next = dist_reg + 1'b1;
                    ram_raddr = idx_inc;
                end
            end
            S_INS: begin
                if (rd_st != rhht_pkg::ST_LIVE) begin
                    ram_we       = 1'b1;
                    ram_wdata    = {rhht_pkg::ST_LIVE, AW'(dist_reg), key_reg, val_reg};
                    new_res_next = 1'b1;
                    if (rd_st == rhht_pkg::ST_EMPTY) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = S_OUT;
                end else begin
                    if (dist_reg > (AW + 1)'(rd_dist)) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rhht_pkg::ST_LIVE, AW'(dist_reg), key_reg, val_reg};
                        key_next  = rd_key;
                        val_next  = rd_val;
                        dist_next = (AW + 1)'(rd_dist) + 1'b1;
                    end else begin
                        dist_next = dist_reg + 1'b1;
                    end
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc;
                end
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = {rhht_pkg::ST_EMPTY, AW'(0), KW'(0), VW'(0)};
                idx_next  = idx_inc;
                if (idx_reg == AW'(SLOT_COUNT - 1)) begin
                    fill_next  = '0;
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_res_reg;
                    m_new_next   = new_res_reg;
                    m_full_next  = full_res_reg;
                    m_rval_next  = rval_res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            init_reg    <= 1'b1;
            idx_reg     <= '0;
            fill_reg    <= '0;
            lim_reg     <= 7'(rhht_pkg::LOAD_LIMIT_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            idx_reg     <= idx_next;
            fill_reg    <= fill_next;
            lim_reg     <= lim_next;
            m_valid_reg <= m_valid_next;
        end
        dist_reg     <= dist_next;
        home_reg     <= home_next;
        cnt_reg      <= cnt_next;
        quot_reg     <= quot_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        hash_reg     <= hash_next;
        val_reg      <= val_next;
        hit_res_reg  <= hit_res_next;
        new_res_reg  <= new_res_next;
        full_res_reg <= full_res_next;
        rval_res_reg <= rval_res_next;
        m_hit_reg    <= m_hit_next;
        m_new_reg    <= m_new_next;
        m_full_reg   <= m_full_next;
        m_rval_reg   <= m_rval_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_new_key    = m_new_reg;
    assign m_full_res   = m_full_reg;
    assign m_read_value = m_rval_reg;

endmodule

// File: rtl/core/rhht_ram.sv
// ----------------------------------------------------------------------------
// Generic slot RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rhht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/rhht_checker.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table checker
// Port-level assertions on result consistency and handshake behavior.
// ----------------------------------------------------------------------------
module rhht_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_hit,
    input logic                         m_new_key,
    input logic                         m_full_res,
    input logic [rhht_pkg::VALUE_W-1:0] m_read_value
);

    // A result beat reports at most one outcome.
    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !((m_hit && m_new_key) || (m_hit && m_full_res)
                      || (m_new_key && m_full_res)))
        else $error("result beat reports more than one outcome");

    // A nonzero value is only returned with a hit.
    a_value_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_value != '0)) |-> m_hit)
        else $error("read value without hit");

    // An accepted input beat is never taken in the cycle after another one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value) && $stable(m_hit)))
        else $error("stalled result changed");

endmodule

bind robin_hood_hash_table_unit rhht_checker u_rhht_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hit       (m_hit),
    .m_new_key   (m_new_key),
    .m_full_res  (m_full_res),
    .m_read_value(m_read_value)
);
